>>> src/prrb_pkg.sv
// ----------------------------------------------------------------------------
// prrb_pkg: shared types and constants of the round-robin balancer
// Sizes, operation codes, sequencer states and the structs that pass
// between the sequencer, the queue store and the top level.
// ----------------------------------------------------------------------------
package prrb_pkg;

  // Block sizes
  localparam int NUM_SERVERS   = 8;
  localparam int NUM_ENDPOINTS = 4;

  // Field widths fixed by the interface
  localparam int ID_W  = 3;
  localparam int EPF_W = 2;
  localparam int TAG_W = 16;

  // Derived widths
  localparam int SLOT_W    = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int CNT_W     = $clog2(NUM_SERVERS + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int EP_W      = (NUM_ENDPOINTS > 1) ? $clog2(NUM_ENDPOINTS) : 1;
  localparam int ADDR_W    = EP_W + SLOT_W;
  localparam int MEM_DEPTH = NUM_ENDPOINTS << SLOT_W;

  // Operation codes
  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_STATUS  = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_REQ_WB,
    S_SCAN,
    S_APPLY,
    S_COMPACT
  } st_t;

  // Queue store access for one cycle
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ID_W-1:0]   wr_data;
  } mem_req_t;

  // Result handed to the output register
  typedef struct packed {
    logic            load;
    logic            found;
    logic [ID_W-1:0] chosen;
  } res_t;

endpackage

>>> src/prrb_store.sv
// ----------------------------------------------------------------------------
// prrb_store: queue entry store
// One write and one registered read per cycle. A valid bit per entry makes
// an entry never written read as its reset value, the slot number itself.
// ----------------------------------------------------------------------------
module prrb_store
  import prrb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  mem_req_t        mreq,
  output logic [ID_W-1:0] rd_data
);

  logic [ID_W-1:0] mem   [MEM_DEPTH];
  logic            valid [MEM_DEPTH];

  // Write the entry array
  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
  end

  // Mark written entries
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MEM_DEPTH; k++) begin
        valid[k] <= 1'b0;
      end
    end else if (mreq.wr_en) begin
      valid[mreq.wr_addr] <= 1'b1;
    end
  end

  // Register the read data, falling back to the reset value
  always_ff @(posedge clk) begin
    if (mreq.rd_en) begin
      if (valid[mreq.rd_addr]) begin
        rd_data <= mem[mreq.rd_addr];
      end else begin
        rd_data <= ID_W'(mreq.rd_addr[SLOT_W-1:0]);
      end
    end
  end

endmodule

>>> src/prrb_seq.sv
// ----------------------------------------------------------------------------
// prrb_seq: balancer sequencer
// Holds queue heads and counts, drives the queue store and steps requests
// and status changes through one shared wrap-around slot adder.
// ----------------------------------------------------------------------------
module prrb_seq
  import prrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             op,
  input  logic [EPF_W-1:0] endpoint,
  input  logic [ID_W-1:0]  server,
  input  logic             up,
  input  logic [ID_W-1:0]  rd_data,
  output logic             busy,
  output mem_req_t         mreq,
  output res_t             res
);

  st_t state, state_next;

  logic [SLOT_W-1:0] head  [NUM_ENDPOINTS];
  logic [CNT_W-1:0]  count [NUM_ENDPOINTS];
  logic [ID_W-1:0]   kept  [NUM_SERVERS];

  logic [EP_W-1:0]   e_q;
  logic [ID_W-1:0]   srv_q;
  logic              up_q;
  logic              hit_q;
  logic [SLOT_W-1:0] nhead_q;
  logic [CNT_W-1:0]  i_q;
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  j_q;
  logic              holds_q;
  logic              pend_q;

  logic              acc;
  logic              ep_ok;
  logic              srv_ok;
  logic [EP_W-1:0]   cur;
  logic [SLOT_W-1:0] cur_head;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  sa_off;
  logic [SUM_W-1:0]  sa_sum;
  logic [SLOT_W-1:0] sa_slot;
  logic              last_ep;
  logic              scan_rd;
  logic              can_add;
  logic              cmp_wr;

  assign acc     = start && !busy;
  assign busy    = (state != S_IDLE);
  assign ep_ok   = (32'(endpoint) < NUM_ENDPOINTS);
  assign srv_ok  = (32'(server) < NUM_SERVERS);
  assign last_ep = (e_q == EP_W'(NUM_ENDPOINTS - 1));

  // Select the endpoint under work: the request port when idle
  assign cur      = (state == S_IDLE) ? EP_W'(endpoint) : e_q;
  assign cur_head = head[cur];
  assign cur_cnt  = count[cur];

  // Shared slot adder: (head + offset) wrapped once into the ring
  always_comb begin
    case (state)
      S_IDLE:  sa_off = CNT_W'(1);
      S_SCAN:  sa_off = i_q;
      default: sa_off = cur_cnt;
    endcase
  end
  assign sa_sum  = SUM_W'(cur_head) + SUM_W'(sa_off);
  assign sa_slot = (sa_sum >= SUM_W'(NUM_SERVERS)) ?
                   SLOT_W'(sa_sum - SUM_W'(NUM_SERVERS)) : SLOT_W'(sa_sum);

  assign scan_rd = (i_q < cur_cnt);
  assign can_add = !holds_q && (cur_cnt < CNT_W'(NUM_SERVERS));
  assign cmp_wr  = (j_q < n_q);

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and store/result drive
  always_comb begin
    state_next = state;
    mreq       = '0;
    res        = '0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (op == OP_REQUEST) begin
            mreq.rd_en   = ep_ok && (cur_cnt != '0);
            mreq.rd_addr = {cur, cur_head};
            state_next   = S_REQ_WB;
          end else if (srv_ok) begin
            state_next = S_SCAN;
          end
        end
      end
      S_REQ_WB: begin
        mreq.wr_en   = hit_q;
        mreq.wr_addr = {e_q, sa_slot};
        mreq.wr_data = rd_data;
        res.load     = 1'b1;
        res.found    = hit_q;
        res.chosen   = hit_q ? rd_data : '0;
        state_next   = S_IDLE;
      end
      S_SCAN: begin
        mreq.rd_en   = scan_rd;
        mreq.rd_addr = {e_q, sa_slot};
        if (!scan_rd && !pend_q) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (up_q) begin
          mreq.wr_en   = can_add;
          mreq.wr_addr = {e_q, sa_slot};
          mreq.wr_data = srv_q;
          state_next   = last_ep ? S_IDLE : S_SCAN;
        end else begin
          state_next = S_COMPACT;
        end
      end
      S_COMPACT: begin
        mreq.wr_en   = cmp_wr;
        mreq.wr_addr = {e_q, SLOT_W'(j_q)};
        mreq.wr_data = kept[SLOT_W'(j_q)];
        if (!cmp_wr) begin
          state_next = last_ep ? S_IDLE : S_SCAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Queue heads and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_ENDPOINTS; k++) begin
        head[k]  <= '0;
        count[k] <= CNT_W'(NUM_SERVERS);
      end
    end else begin
      case (state)
        S_REQ_WB: begin
          if (hit_q) begin
            head[e_q] <= nhead_q;
          end
        end
        S_APPLY: begin
          if (up_q && can_add) begin
            count[e_q] <= cur_cnt + CNT_W'(1);
          end
        end
        S_COMPACT: begin
          if (!cmp_wr) begin
            head[e_q]  <= '0;
            count[e_q] <= n_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Scan side buffer: keep entries other than the named server
  always_ff @(posedge clk) begin
    if (state == S_SCAN && pend_q && rd_data != srv_q) begin
      kept[SLOT_W'(n_q)] <= rd_data;
    end
  end

  // Working registers of the current item
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_q <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            e_q     <= (op == OP_REQUEST) ? cur : '0;
            srv_q   <= server;
            up_q    <= up;
            hit_q   <= ep_ok && (cur_cnt != '0);
            nhead_q <= sa_slot;
            i_q     <= '0;
            n_q     <= '0;
            holds_q <= 1'b0;
            pend_q  <= 1'b0;
          end
        end
        S_SCAN: begin
          pend_q <= scan_rd;
          if (scan_rd) begin
            i_q <= i_q + CNT_W'(1);
          end
          if (pend_q) begin
            if (rd_data == srv_q) begin
              holds_q <= 1'b1;
            end else begin
              n_q <= n_q + CNT_W'(1);
            end
          end
        end
        S_APPLY: begin
          j_q <= '0;
          if (up_q) begin
            e_q     <= e_q + EP_W'(1);
            i_q     <= '0;
            n_q     <= '0;
            holds_q <= 1'b0;
          end
        end
        S_COMPACT: begin
          if (cmp_wr) begin
            j_q <= j_q + CNT_W'(1);
          end else begin
            e_q     <= e_q + EP_W'(1);
            i_q     <= '0;
            n_q     <= '0;
            holds_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_req_result: assert property (@(posedge clk) disable iff (rst)
    (acc && op == OP_REQUEST) |=> res.load)
    else $error("request did not produce a result next cycle");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(mreq.rd_en && mreq.wr_en))
    else $error("store read and write in the same cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cur_cnt <= CNT_W'(NUM_SERVERS))
    else $error("queue count above server count");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (n_q <= i_q))
    else $error("kept entries exceed scanned entries");

endmodule

>>> src/per_endpoint_round_robin_balancer_top.sv
// ----------------------------------------------------------------------------
// per_endpoint_round_robin_balancer_top: per-endpoint round-robin balancer
// Rotates one server queue per endpoint on requests and removes or appends
// servers in every queue on status changes.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------
//   command  | start / busy       | op, endpoint, server, up, req_tag
//   result   | done (one cycle)   | found, chosen_server, tag_out
//
// A request holds busy high for one cycle and done pulses in
// the cycle after, when the next transfer may already be taken.
// A status change walks every endpoint queue through the single store port:
// a scan and an append per queue for up, a scan and a compaction for down.
// Status changes give no result; a server out of range is dropped at once.
// Reset is synchronous; the queue store needs no clearing pass after it.
// done cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module per_endpoint_round_robin_balancer_top
  import prrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             op,
  input  logic [EPF_W-1:0] endpoint,
  input  logic [ID_W-1:0]  server,
  input  logic             up,
  input  logic [TAG_W-1:0] req_tag,
  output logic             done,
  output logic             found,
  output logic [ID_W-1:0]  chosen_server,
  output logic [TAG_W-1:0] tag_out
);

  mem_req_t          mreq;
  res_t              res;
  logic [ID_W-1:0]   rd_data;
  logic [TAG_W-1:0]  tag_q;
  logic              server_up [NUM_SERVERS];
  logic              acc;
  logic              status_acc;
  logic [SLOT_W-1:0] srv_idx;

  assign acc        = start && !busy;
  assign status_acc = acc && (op == OP_STATUS) && (32'(server) < NUM_SERVERS);
  assign srv_idx    = SLOT_W'(server);

  prrb_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .op       (op),
    .endpoint (endpoint),
    .server   (server),
    .up       (up),
    .rd_data  (rd_data),
    .busy     (busy),
    .mreq     (mreq),
    .res      (res)
  );

  prrb_store u_store (
    .clk     (clk),
    .rst     (rst),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

  // Capture the tag of each accepted transfer
  always_ff @(posedge clk) begin
    if (acc) begin
      tag_q <= req_tag;
    end
  end

  // Record server up flags
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_SERVERS; k++) begin
        server_up[k] <= 1'b1;
      end
    end else if (status_acc) begin
      server_up[srv_idx] <= up;
    end
  end

  // Register the result and pulse done
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res.load;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      found         <= res.found;
      chosen_server <= res.chosen;
      tag_out       <= tag_q;
    end
  end

  // Checks
  a_done_follows_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && op == OP_REQUEST, 2))
    else $error("result without a request two cycles earlier");

  a_flag_update: assert property (@(posedge clk) disable iff (rst)
    status_acc |=> (server_up[$past(srv_idx)] == $past(up)))
    else $error("server flag not updated by status change");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (chosen_server == '0))
    else $error("empty result carries a server index");

endmodule

>>> tb/sv/per_endpoint_round_robin_balancer_checker.sv
// ----------------------------------------------------------------------------
// per_endpoint_round_robin_balancer_checker: result checker of the balancer
// Watches the command and result channels, keeps its own copy of the
// per-endpoint server rings and up flags, predicts the pick for every
// accepted request and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module per_endpoint_round_robin_balancer_checker
  import prrb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             busy,
  input  logic             op,
  input  logic [EPF_W-1:0] endpoint,
  input  logic [ID_W-1:0]  server,
  input  logic             up,
  input  logic [TAG_W-1:0] req_tag,
  input  logic             done,
  input  logic             found,
  input  logic [ID_W-1:0]  chosen_server,
  input  logic [TAG_W-1:0] tag_out,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic             found;
    logic [ID_W-1:0]  chosen;
    logic [TAG_W-1:0] tag;
  } pick_t;

  // Predicted state: one ring of server ids per endpoint, one up flag per server
  logic [ID_W-1:0] ring [NUM_ENDPOINTS][NUM_SERVERS];
  int unsigned     ring_head [NUM_ENDPOINTS];
  int unsigned     ring_count [NUM_ENDPOINTS];
  bit              server_is_up [NUM_SERVERS];

  pick_t expected_picks [$];

  function automatic int unsigned wrap(int unsigned head, int unsigned offset);
    return (head + offset) % NUM_SERVERS;
  endfunction

  function automatic void reset_rings();
    for (int e = 0; e < NUM_ENDPOINTS; e++) begin
      for (int s = 0; s < NUM_SERVERS; s++) ring[e][s] = ID_W'(s);
      ring_head[e]  = 0;
      ring_count[e] = NUM_SERVERS;
    end
    for (int s = 0; s < NUM_SERVERS; s++) server_is_up[s] = 1'b1;
  endfunction

  function automatic bit ring_holds(int unsigned e, logic [ID_W-1:0] srv);
    for (int unsigned i = 0; i < ring_count[e]; i++) begin
      if (ring[e][wrap(ring_head[e], i)] == srv) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Drop the server and pack the survivors from slot 0, order kept
  function automatic void ring_drop(int unsigned e, logic [ID_W-1:0] srv);
    logic [ID_W-1:0] kept [NUM_SERVERS];
    int unsigned     n;
    n = 0;
    for (int unsigned i = 0; i < ring_count[e]; i++) begin
      if (ring[e][wrap(ring_head[e], i)] != srv) begin
        kept[n] = ring[e][wrap(ring_head[e], i)];
        n++;
      end
    end
    for (int unsigned i = 0; i < n; i++) ring[e][i] = kept[i];
    ring_head[e]  = 0;
    ring_count[e] = n;
  endfunction

  // Append at the tail unless full or already queued
  function automatic void ring_add(int unsigned e, logic [ID_W-1:0] srv);
    if (ring_count[e] >= NUM_SERVERS || ring_holds(e, srv)) return;
    ring[e][wrap(ring_head[e], ring_count[e])] = srv;
    ring_count[e]++;
  endfunction

  // Take the front server of the endpoint's ring and rotate it to the tail
  function automatic pick_t pick_server(logic [EPF_W-1:0] ep, logic [TAG_W-1:0] tag);
    pick_t           res;
    int unsigned     e;
    logic [ID_W-1:0] v;
    res.found  = 1'b0;
    res.chosen = '0;
    res.tag    = tag;
    e = ep;
    if (e < NUM_ENDPOINTS && ring_count[e] != 0) begin
      v = ring[e][ring_head[e]];
      ring[e][wrap(ring_head[e], ring_count[e])] = v;
      ring_head[e] = wrap(ring_head[e], 1);
      res.found  = 1'b1;
      res.chosen = v;
    end
    return res;
  endfunction

  function automatic void apply_status(logic [ID_W-1:0] srv, logic is_up);
    if (int'(srv) >= NUM_SERVERS) return;
    server_is_up[srv] = is_up;
    for (int e = 0; e < NUM_ENDPOINTS; e++) begin
      if (is_up) ring_add(e, srv);
      else ring_drop(e, srv);
    end
  endfunction

  // Compare results first, then predict the transfer taken at the same edge
  always @(posedge clk) begin
    pick_t want;
    if (rst) begin
      reset_rings();
      expected_picks.delete();
      fail_count = 0;
    end else begin
      if (done) begin
        if (expected_picks.size() == 0) begin
          $error("result with no request waiting: tag_out %0h", tag_out);
          fail_count++;
        end else begin
          want = expected_picks.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, found);
            fail_count++;
          end
          if (chosen_server !== want.chosen) begin
            $error("chosen_server: expected %0d, got %0d", want.chosen, chosen_server);
            fail_count++;
          end
          if (tag_out !== want.tag) begin
            $error("tag_out: expected %0h, got %0h", want.tag, tag_out);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        if (op == OP_REQUEST) expected_picks.push_back(pick_server(endpoint, req_tag));
        else apply_status(server, up);
      end
    end
    pending = expected_picks.size();
  end

endmodule

>>> tb/sv/per_endpoint_round_robin_balancer_top_tb.sv
// ----------------------------------------------------------------------------
// per_endpoint_round_robin_balancer_top_tb: testbench of the balancer
// Drives directed and random requests and server status changes with
// random idle gaps, lets the checker predict and compare every result,
// and reports the verdict once all results have come back.
// ----------------------------------------------------------------------------
module per_endpoint_round_robin_balancer_top_tb;
  import prrb_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             op;
  logic [EPF_W-1:0] endpoint;
  logic [ID_W-1:0]  server;
  logic             up;
  logic [TAG_W-1:0] req_tag;
  logic             done;
  logic             found;
  logic [ID_W-1:0]  chosen_server;
  logic [TAG_W-1:0] tag_out;

  int fail_count;
  int pending;
  int cycle_count;
  bit no_gaps;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  per_endpoint_round_robin_balancer_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .endpoint      (endpoint),
    .server        (server),
    .up            (up),
    .req_tag       (req_tag),
    .done          (done),
    .found         (found),
    .chosen_server (chosen_server),
    .tag_out       (tag_out)
  );

  per_endpoint_round_robin_balancer_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .endpoint      (endpoint),
    .server        (server),
    .up            (up),
    .req_tag       (req_tag),
    .done          (done),
    .found         (found),
    .chosen_server (chosen_server),
    .tag_out       (tag_out),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Present one command, hold it until transferred, then idle for a random gap
  task automatic send_cmd(input logic o, input logic [EPF_W-1:0] ep,
                          input logic [ID_W-1:0] srv, input logic u,
                          input logic [TAG_W-1:0] tag);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 70) gap = 0;
    else if (roll < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    @(negedge clk);
    start    <= 1'b1;
    op       <= o;
    endpoint <= ep;
    server   <= srv;
    up       <= u;
    req_tag  <= tag;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic request(input logic [EPF_W-1:0] ep, input logic [TAG_W-1:0] tag);
    send_cmd(OP_REQUEST, ep, ID_W'($urandom), 1'($urandom), tag);
  endtask

  task automatic set_status(input logic [ID_W-1:0] srv, input logic u);
    send_cmd(OP_STATUS, EPF_W'($urandom), srv, u, TAG_W'($urandom));
  endtask

  initial begin
    int roll;
    rst      = 1'b1;
    start    = 1'b0;
    op       = OP_REQUEST;
    endpoint = '0;
    server   = '0;
    up       = 1'b0;
    req_tag  = '0;
    no_gaps  = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: tag extremes, up for a queued server, down twice, empty rings
    request(0, 16'h0000);
    request(0, 16'hFFFF);
    request(3, 16'h5A5A);
    set_status(2, 1'b1);
    set_status(7, 1'b0);
    set_status(7, 1'b0);
    for (int s = 0; s < NUM_SERVERS - 1; s++) set_status(ID_W'(s), 1'b0);
    request(1, 16'h1234);
    request(2, 16'hFFFF);
    set_status(7, 1'b1);
    set_status(0, 1'b1);
    set_status(7, 1'b1);
    request(0, 16'hA5A5);
    request(0, 16'h0001);
    request(0, 16'h8000);
    request(3, 16'hFFFF);

    // Random: mostly requests, status changes leaning towards up
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 9) < 3);
      roll = $urandom_range(0, 99);
      if (roll < 82) request(EPF_W'($urandom), TAG_W'($urandom));
      else set_status(ID_W'($urandom), ($urandom_range(0, 9) < 6));
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
